### rtl/midi_track_event_encoder_macros.svh
// Assertion macros shared by the encoder's RTL modules.
// Depends on: clk and rst_n existing in the module that uses them.
`ifndef MIDI_TRACK_EVENT_ENCODER_MACROS_SVH
`define MIDI_TRACK_EVENT_ENCODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define MTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mte assertion failed");
// Next-cycle implication, disabled during reset.
`define MTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mte assertion failed");
`else
`define MTE_ASSERT_NOW(label, ante, cons)
`define MTE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/mte_pkg.sv
// Types, constants and helpers shared by the MIDI track event encoder.
// Depends on: nothing.
package mte_pkg;

  typedef struct packed {
    logic        req_type;
    logic [30:0] event_tick;
    logic [7:0]  msg_byte;
    logic        first_of_message;
    logic        multi_byte_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       no_output;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_PASS  = 2'd0,
    JOB_FIRST = 2'd1,
    JOB_EOT   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [30:0] delta;
    logic [7:0]  msg_byte;
    logic        elide;
  } job_t;

  localparam int          FIFO_DEPTH = 4;
  localparam int          FIFO_AW    = 2;
  localparam int          IDX_W      = 3;
  localparam logic [7:0]  MORE_BIT   = 8'h80;
  localparam logic [3:0]  SYS_NIBBLE = 4'hF;
  localparam logic [2:0]  EOT_LEN    = 3'd4;

  // End-of-track meta event: 00 FF 2F 00
  function automatic logic [7:0] eot_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'hFF;
      2'd2:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/midi_track_event_encoder.sv
// MIDI track event encoder: accepted items are queued as jobs and expanded into a registered output,
// one output byte per cycle while out_ready stays high and jobs are queued.
// A status or data byte yields one output item of the back end; a message's first byte
// yields 1 to 6 (delta VLQ bytes plus status); end of track yields 4 items.
// Input takes one item per cycle until the 4-entry job queue fills.
// rst_n (synchronous, active low) clears running-status state, queue and output.
module midi_track_event_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mte_pkg::out_item_t out_data
);

  // Front end -> queue: classified jobs carrying the clamped delta and
  // the running-status decision, already resolved at acceptance time.
  logic          job_valid;
  logic          job_ready;
  mte_pkg::job_t job_data;

  // Queue -> back end.
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  mte_pkg::job_t q_head;

  // Front end: owns previous tick, previous status and the first-event flag.
  // Since all state follows the order of accepted items, it is updated at
  // acceptance and the back end never needs to see it.
  mte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data)
  );

  // Hold jobs while the back end expands a long run; stall input only on full.
  assign job_ready = !q_full;

  mte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid && job_ready),
    .push_data (job_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back end: walk each job one byte per cycle, while the output can take it, into a registered output;
  // the next job is loaded on the cycle the current run's last byte leaves.
  mte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job_head  (q_head),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/mte_front.sv
// Front end: accepts input items, tracks running-status state, builds jobs.
// Depends on: mte_pkg.
module mte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mte_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output mte_pkg::job_t     job_data
);

  logic [30:0] prev_tick_r;
  logic [7:0]  prev_status_r;
  logic        seen_r;
  logic        accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  always_comb begin
    job_data.delta    = (in_data.event_tick > prev_tick_r) ?
                        (in_data.event_tick - prev_tick_r) : 31'd0;
    job_data.msg_byte = in_data.msg_byte;
    job_data.elide    = (in_data.msg_byte == prev_status_r) &&
                        (in_data.msg_byte[7:4] != mte_pkg::SYS_NIBBLE) &&
                        seen_r && in_data.multi_byte_message;
    if (in_data.req_type) begin
      job_data.kind = mte_pkg::JOB_EOT;
    end else if (in_data.first_of_message) begin
      job_data.kind = mte_pkg::JOB_FIRST;
    end else begin
      job_data.kind = mte_pkg::JOB_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r   <= '0;
      prev_status_r <= '0;
      seen_r        <= 1'b0;
    end else if (accept) begin
      if (in_data.req_type) begin
        // terminator starts a fresh track
        prev_tick_r   <= '0;
        prev_status_r <= '0;
        seen_r        <= 1'b0;
      end else if (in_data.first_of_message) begin
        prev_tick_r   <= in_data.event_tick;
        prev_status_r <= in_data.msg_byte;
        seen_r        <= 1'b1;
      end
    end
  end

endmodule

### rtl/mte_fifo.sv
// Short job queue between front and back end.
// Depends on: mte_pkg, midi_track_event_encoder_macros.svh.
`include "midi_track_event_encoder_macros.svh"
module mte_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mte_pkg::job_t  push_data,
  output logic           full,
  input  logic           pop,
  output mte_pkg::job_t  head,
  output logic           empty
);

  localparam logic [mte_pkg::FIFO_AW:0] DEPTH_V =
    (mte_pkg::FIFO_AW + 1)'(mte_pkg::FIFO_DEPTH);

  mte_pkg::job_t                mem_r [mte_pkg::FIFO_DEPTH];
  logic [mte_pkg::FIFO_AW:0]    wr_ptr_r;
  logic [mte_pkg::FIFO_AW:0]    rd_ptr_r;
  logic [mte_pkg::FIFO_AW:0]    fill;

  assign fill  = wr_ptr_r - rd_ptr_r;
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (fill == DEPTH_V);
  assign head  = mem_r[rd_ptr_r[mte_pkg::FIFO_AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[mte_pkg::FIFO_AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  `MTE_ASSERT_NOW(a_fill_bound, 1'b1, fill <= DEPTH_V)
  `MTE_ASSERT_NOW(a_no_overflow, push, !full)
  `MTE_ASSERT_NOW(a_no_underflow, pop, !empty)

endmodule

### rtl/mte_back.sv
// Back end: expands one job per run into delta VLQ, status, data or end-of-track bytes.
// Depends on: mte_pkg, midi_track_event_encoder_macros.svh.
`include "midi_track_event_encoder_macros.svh"
module mte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  mte_pkg::job_t      job_head,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mte_pkg::out_item_t out_data
);

  mte_pkg::job_t                 cur_r;
  logic                          busy_r;
  logic [mte_pkg::IDX_W-1:0]     idx_r;
  logic [mte_pkg::IDX_W-1:0]     idx_nxt;
  logic                          out_valid_r;
  mte_pkg::out_item_t            out_data_r;

  logic [mte_pkg::IDX_W-1:0]     ngroups;
  logic [mte_pkg::IDX_W-1:0]     run_len;
  logic [mte_pkg::IDX_W-1:0]     grp;
  logic [6:0]                    grp_bits;
  logic                          emit;
  logic                          last_now;
  mte_pkg::out_item_t            item;

  // number of 7-bit groups the delta needs
  always_comb begin
    if (cur_r.delta[30:28] != '0) begin
      ngroups = 3'd5;
    end else if (cur_r.delta[27:21] != '0) begin
      ngroups = 3'd4;
    end else if (cur_r.delta[20:14] != '0) begin
      ngroups = 3'd3;
    end else if (cur_r.delta[13:7] != '0) begin
      ngroups = 3'd2;
    end else begin
      ngroups = 3'd1;
    end
  end

  always_comb begin
    unique case (cur_r.kind)
      mte_pkg::JOB_PASS:  run_len = 3'd1;
      mte_pkg::JOB_FIRST: run_len = ngroups + {2'b00, !cur_r.elide};
      mte_pkg::JOB_EOT:   run_len = mte_pkg::EOT_LEN;
      default:            run_len = 3'd1;
    endcase
  end

  // most significant group first
  assign grp = ngroups - 3'd1 - idx_r;

  always_comb begin
    unique case (grp)
      3'd0:    grp_bits = cur_r.delta[6:0];
      3'd1:    grp_bits = cur_r.delta[13:7];
      3'd2:    grp_bits = cur_r.delta[20:14];
      3'd3:    grp_bits = cur_r.delta[27:21];
      3'd4:    grp_bits = {4'b0000, cur_r.delta[30:28]};
      default: grp_bits = 7'd0;
    endcase
  end

  assign last_now = (idx_r == run_len - 3'd1);
  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign job_pop  = job_avail && (!busy_r || (emit && last_now));
  assign idx_nxt  = idx_r + 3'd1;

  always_comb begin
    item.last_of_run = last_now;
    item.no_output   = 1'b0;
    unique case (cur_r.kind)
      mte_pkg::JOB_PASS: item.out_byte = cur_r.msg_byte;
      mte_pkg::JOB_FIRST: begin
        if (idx_r < ngroups) begin
          item.out_byte = {(grp != 3'd0), grp_bits};
          item.no_output = last_now;
        end else begin
          item.out_byte = cur_r.msg_byte;
        end
      end
      mte_pkg::JOB_EOT:  item.out_byte = mte_pkg::eot_byte(idx_r[1:0]);
      default:           item.out_byte = cur_r.msg_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job_head;
    end
    if (emit) begin
      out_data_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit && last_now) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MTE_ASSERT_NOW(a_idx_in_run, busy_r, idx_r < run_len)
  `MTE_ASSERT_NEXT(a_pop_loads, job_pop, busy_r && (idx_r == '0))
  `MTE_ASSERT_NOW(a_elide_marks_last, out_valid_r && out_data_r.no_output, out_data_r.last_of_run)

endmodule
